FILE: rtl/core/gasa_pkg.sv
// Shared constants for the glyph atlas shelf allocator.
// Stream widths, configuration register indexes, status codes and reset values.
// No dependencies.
package gasa_pkg;

  // Default upper bound on atlas width
  localparam int AtlasMaxDefault = 4096;

  // Coordinate and width fields
  localparam int CoordW = 13;
  localparam logic [CoordW-1:0] CoordLimit = 13'h1FFF;
  localparam int GlyphW = 10;
  localparam int PlacedW = 11;
  localparam int RowHW = 10;
  localparam int PadW = 4;

  // Stream payload widths
  localparam int InTdataW = 24;
  localparam int OutTdataW = 56;
  localparam int OutTuserW = 2;

  // Configuration port
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 13;
  localparam logic [CfgAddrW-1:0] RegPadding = 3'd0;
  localparam logic [CfgAddrW-1:0] RegStartWidth = 3'd1;
  localparam logic [CfgAddrW-1:0] RegMaxWidth = 3'd2;
  localparam logic [CfgAddrW-1:0] RegMaxHeight = 3'd3;
  localparam logic [CfgAddrW-1:0] RegMonoAlign = 3'd4;

  // Register reset values
  localparam logic [CoordW-1:0] StartWidthRst = 13'd256;
  localparam logic [CoordW-1:0] MaxWidthRst = 13'd4096;
  localparam logic [CoordW-1:0] MaxHeightRst = 13'd4096;

  // Result status codes
  localparam logic [OutTuserW-1:0] StPlaced = 2'd0;
  localparam logic [OutTuserW-1:0] StEmpty = 2'd1;
  localparam logic [OutTuserW-1:0] StNoRoom = 2'd2;

endpackage

FILE: rtl/core/glyph_atlas_shelf_allocator.sv
// Glyph atlas shelf allocator: top level.
// Depends on gasa_pkg for widths, register indexes and status codes.
//
// Usage:
//   Input stream s_axis carries one glyph per transaction: glyph width and
//   height. Output stream m_axis returns one result per glyph: position,
//   width after mono alignment and current atlas width in tdata, and the
//   status (placed, empty glyph skipped, no room in height) in tuser.
//   Registers are written through cfg_we_i / cfg_addr_i / cfg_wdata_i while
//   the block is idle; a write takes effect at the same clock edge.
// Timing:
//   A glyph is captured in an input register, placed by one pass of
//   combinational logic against the packer state, and the result lands in
//   the output register. One glyph per cycle sustained while the output is
//   not stalled; the packer state (cursor, row height, atlas width) updates
//   in the same cycle the glyph is placed.
// Reset:
//   Cursors and row height clear, atlas width takes the start width, and
//   both streams come up empty with s_axis_tready high.
// Backpressure:
//   When m_axis_tready is low the result holds; one more glyph waits in the
//   input register, after which s_axis_tready drops.
module glyph_atlas_shelf_allocator #(
  parameter int ATLAS_MAX = gasa_pkg::AtlasMaxDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [gasa_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [gasa_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Glyph input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [9:0] box width, [19:10] box height, [23:20] zero
  input  logic [gasa_pkg::InTdataW-1:0]  s_axis_tdata,
  // Placement result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [12:0] pos_x, [25:13] pos_y, [36:26] placed_width, [49:37] atlas_width,
  // [55:50] zero
  output logic [gasa_pkg::OutTdataW-1:0] m_axis_tdata,
  // [1:0] status
  output logic [gasa_pkg::OutTuserW-1:0] m_axis_tuser
);

  localparam int CW = gasa_pkg::CoordW;
  localparam int SumW = CW + 2;
  localparam int MaxShift = CW - 1;
  localparam int CandW = CW + MaxShift;
  // Effective clamp for widths: never beyond what a coordinate can hold
  localparam int ClampInt = (ATLAS_MAX > 8191) ? 8191 : ATLAS_MAX;
  localparam logic [CW-1:0] ClampW = CW'(ClampInt);
  localparam logic [CW-1:0] StartRst =
    (gasa_pkg::StartWidthRst > ClampW) ? ClampW : gasa_pkg::StartWidthRst;

  // Configuration registers
  logic [gasa_pkg::PadW-1:0] pad_q;
  logic [CW-1:0]             max_w_q;
  logic [CW-1:0]             max_h_q;
  logic                      mono_q;

  // Packer state
  logic [CW-1:0]             cur_x_q, cur_x_d;
  logic [CW-1:0]             cur_y_q, cur_y_d;
  logic [gasa_pkg::RowHW-1:0] row_h_q, row_h_d;
  logic [CW-1:0]             atlas_w_q, atlas_w_d;
  logic                      locked_q;

  // Input register
  logic                        in_valid_q;
  logic [gasa_pkg::GlyphW-1:0] in_w_q, in_h_q;

  // Output register
  logic                           out_valid_q;
  logic [gasa_pkg::OutTdataW-1:0] out_data_q, out_data_d;
  logic [gasa_pkg::OutTuserW-1:0] out_user_q, out_user_d;

  logic advance, fire, s_fire;
  logic [CW-1:0] start_eff;

  // Handshake: the input register drains whenever the output can take a result
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Start width clamped into 1..ATLAS_MAX
  always_comb begin
    if (cfg_wdata_i == '0) begin
      start_eff = CW'(1);
    end else if (cfg_wdata_i > ClampW) begin
      start_eff = ClampW;
    end else begin
      start_eff = cfg_wdata_i;
    end
  end

  // Placement datapath
  logic [CW-1:0]       cx0, cy0, cx1, cy1, max_w_eff;
  logic [gasa_pkg::PlacedW-1:0] wa;
  logic [gasa_pkg::RowHW-1:0]   rh1, rh2;
  logic [SumW-1:0]     need, row_sum, adv_sum, bottom;
  logic [CandW-1:0]    cand;
  logic                grow_ok, no_room, is_empty;
  logic [CW-1:0]       new_w;

  always_comb begin
    cx0 = cur_x_q;
    cy0 = cur_y_q;
    if (cur_x_q == '0 && cur_y_q == '0) begin
      cx0 = CW'(pad_q);
      cy0 = CW'(pad_q);
    end

    is_empty  = (in_w_q == '0) || (in_h_q == '0);
    max_w_eff = (max_w_q > ClampW) ? ClampW : max_w_q;

    // Mono alignment rounds up to a multiple of 8
    if (mono_q) begin
      wa = (gasa_pkg::PlacedW'(in_w_q) + 11'd7) & ~11'd7;
    end else begin
      wa = gasa_pkg::PlacedW'(in_w_q);
    end

    rh1  = (in_h_q > row_h_q) ? in_h_q : row_h_q;
    need = SumW'(cx0) + SumW'(wa) + SumW'(pad_q);

    // Smallest doubling of the width that covers need; all shifts in parallel
    grow_ok = 1'b0;
    new_w   = atlas_w_q;
    for (int k = MaxShift; k >= 1; k--) begin
      cand = CandW'(atlas_w_q) << k;
      if (cand >= CandW'(need) && cand <= CandW'(max_w_eff)) begin
        grow_ok = 1'b1;
        new_w   = cand[CW-1:0];
      end
    end

    // Row overflow: grow the atlas or open a new row
    row_sum   = SumW'(cy0) + SumW'(rh1) + SumW'({pad_q, 1'b0});
    cx1       = cx0;
    cy1       = cy0;
    rh2       = rh1;
    atlas_w_d = atlas_w_q;
    if (need > SumW'(atlas_w_q)) begin
      if (grow_ok) begin
        atlas_w_d = new_w;
      end else begin
        cx1 = CW'(pad_q);
        cy1 = (row_sum > SumW'(gasa_pkg::CoordLimit)) ? gasa_pkg::CoordLimit
                                                       : row_sum[CW-1:0];
        rh2 = in_h_q;
      end
    end

    // Height limit check
    bottom  = SumW'(cy1) + SumW'(in_h_q) + SumW'(pad_q);
    no_room = (max_h_q != '0) && (bottom > SumW'(max_h_q));

    adv_sum = SumW'(cx1) + SumW'(wa) + SumW'({pad_q, 1'b0});

    // Result and next state
    if (is_empty) begin
      cur_x_d    = cx0;
      cur_y_d    = cy0;
      row_h_d    = row_h_q;
      atlas_w_d  = atlas_w_q;
      out_data_d = {6'd0, atlas_w_q, 11'd0, 13'd0, 13'd0};
      out_user_d = gasa_pkg::StEmpty;
    end else if (no_room) begin
      cur_x_d    = cx1;
      cur_y_d    = cy1;
      row_h_d    = rh2;
      out_data_d = {6'd0, atlas_w_d, wa, 13'd0, 13'd0};
      out_user_d = gasa_pkg::StNoRoom;
    end else begin
      cur_x_d    = (adv_sum > SumW'(gasa_pkg::CoordLimit)) ? gasa_pkg::CoordLimit
                                                            : adv_sum[CW-1:0];
      cur_y_d    = cy1;
      row_h_d    = rh2;
      out_data_d = {6'd0, atlas_w_d, wa, cy1, cx1};
      out_user_d = gasa_pkg::StPlaced;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q   <= '0;
      max_w_q <= gasa_pkg::MaxWidthRst;
      max_h_q <= gasa_pkg::MaxHeightRst;
      mono_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        gasa_pkg::RegPadding:   pad_q   <= cfg_wdata_i[gasa_pkg::PadW-1:0];
        gasa_pkg::RegMaxWidth:  max_w_q <= cfg_wdata_i;
        gasa_pkg::RegMaxHeight: max_h_q <= cfg_wdata_i;
        gasa_pkg::RegMonoAlign: mono_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Packer state; atlas width follows the start width until the first non-empty glyph
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      row_h_q   <= '0;
      atlas_w_q <= StartRst;
      locked_q  <= 1'b0;
    end else if (fire) begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      row_h_q   <= row_h_d;
      atlas_w_q <= atlas_w_d;
      if (!is_empty) begin
        locked_q <= 1'b1;
      end
    end else if (cfg_we_i && cfg_addr_i == gasa_pkg::RegStartWidth && !locked_q) begin
      atlas_w_q <= start_eff;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_fire) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_w_q <= s_axis_tdata[gasa_pkg::GlyphW-1:0];
      in_h_q <= s_axis_tdata[2*gasa_pkg::GlyphW-1:gasa_pkg::GlyphW];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

endmodule

FILE: rtl/core/gasa_checker.sv
// Port-level checks for the glyph atlas shelf allocator.
// Depends on gasa_pkg; bound to glyph_atlas_shelf_allocator below.
module gasa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [gasa_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic [gasa_pkg::OutTuserW-1:0] m_axis_tuser
);

  // A stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Input backpressure only comes from a stalled, full output side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

  // Skipped glyphs report zero position and width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == gasa_pkg::StEmpty |->
      m_axis_tdata[36:0] == 37'd0)
    else $error("empty glyph result not zero");

  // Refused glyphs report zero position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == gasa_pkg::StNoRoom |->
      m_axis_tdata[25:0] == 26'd0)
    else $error("no-room result has nonzero position");

endmodule

bind glyph_atlas_shelf_allocator gasa_checker u_gasa_checker (.*);
